// ===== design/sphere_box_contact_macros.svh =====
// assertion macros for the sphere box contact checker
`ifndef SPHERE_BOX_CONTACT_MACROS_SVH
`define SPHERE_BOX_CONTACT_MACROS_SVH

// pre implies post in the same cycle
`define SBC_ASSERT_NOW(name, clk, rst, pre, post, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// pre implies post in the next cycle
`define SBC_ASSERT_NEXT(name, clk, rst, pre, post, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

// ===== design/sbc_pkg.sv =====
// shared constants and types for the sphere box contact block
`default_nettype none
package sbc_pkg;
   localparam int WORD_BITS_DEF = 32;
   localparam int FRAC_BITS_DEF = 16;

   typedef enum logic [1:0] {
      AXIS_X,
      AXIS_Y,
      AXIS_Z
   } axis_type;
endpackage
`default_nettype wire

// ===== design/sbc_sqrt.sv =====
// pipelined integer square root, one root bit per stage, with a side payload
`default_nettype none
module sbc_sqrt #(
   parameter int RB = 31,
   parameter int PW = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          adv,
   input  logic          in_valid,
   input  logic [2*RB-1:0] in_d,
   input  logic [PW-1:0] in_pay,
   output logic          out_valid,
   output logic [RB-1:0] out_root,
   output logic [PW-1:0] out_pay
);
   localparam int DW = 2 * RB;

   logic [DW-1:0] rem_ff  [0:RB-1];
   logic [RB-1:0] root_ff [0:RB-1];
   logic [PW-1:0] pay_ff  [0:RB-1];
   logic [RB-1:0] valid_ff;

   for (genvar i = 0; i < RB; i++) begin : g_stage
      localparam int K = RB - 1 - i;
      logic [DW-1:0] rem_prev, trial, rem_in;
      logic [RB-1:0] root_prev, root_in;
      logic [PW-1:0] pay_prev;
      logic          valid_prev, take;

      if (i == 0) begin : g_first
         assign rem_prev   = in_d;
         assign root_prev  = '0;
         assign pay_prev   = in_pay;
         assign valid_prev = in_valid;
      end else begin : g_next
         assign rem_prev   = rem_ff[i-1];
         assign root_prev  = root_ff[i-1];
         assign pay_prev   = pay_ff[i-1];
         assign valid_prev = valid_ff[i-1];
      end

      always_comb begin
         trial   = (DW'(root_prev) << (K + 1)) + (DW'(1) << (2 * K));
         take    = rem_prev >= trial;
         rem_in  = take ? rem_prev - trial : rem_prev;
         root_in = take ? (root_prev | (RB'(1) << K)) : root_prev;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (adv) begin
            valid_ff[i] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[i]  <= rem_in;
            root_ff[i] <= root_in;
            pay_ff[i]  <= pay_prev;
         end
      end
   end

   assign out_valid = valid_ff[RB-1];
   assign out_root  = root_ff[RB-1];
   assign out_pay   = pay_ff[RB-1];
endmodule
`default_nettype wire

// ===== design/sbc_div.sv =====
// pipelined three lane restoring divider, one quotient bit per stage
`default_nettype none
module sbc_div #(
   parameter int NB = 31,
   parameter int QB = 18,
   parameter int PW = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          adv,
   input  logic          in_valid,
   input  logic [NB-1:0] in_den,
   input  logic [NB-1:0] in_num [3],
   input  logic [PW-1:0] in_pay,
   output logic          out_valid,
   output logic [QB-1:0] out_q [3],
   output logic [PW-1:0] out_pay
);
   logic [NB-1:0] den_ff [0:QB-1];
   logic [NB-1:0] rem_ff [0:QB-1][3];
   logic [QB-1:0] q_ff   [0:QB-1][3];
   logic [PW-1:0] pay_ff [0:QB-1];
   logic [QB-1:0] valid_ff;

   for (genvar j = 0; j < QB; j++) begin : g_stage
      logic [NB-1:0] den_prev;
      logic [NB-1:0] rem_prev [3];
      logic [QB-1:0] q_prev   [3];
      logic [NB-1:0] rem_in   [3];
      logic [QB-1:0] q_in     [3];
      logic [PW-1:0] pay_prev;
      logic          valid_prev;

      if (j == 0) begin : g_first
         assign den_prev   = in_den;
         assign rem_prev   = in_num;
         assign q_prev     = '{default: '0};
         assign pay_prev   = in_pay;
         assign valid_prev = in_valid;
      end else begin : g_next
         assign den_prev   = den_ff[j-1];
         assign rem_prev   = rem_ff[j-1];
         assign q_prev     = q_ff[j-1];
         assign pay_prev   = pay_ff[j-1];
         assign valid_prev = valid_ff[j-1];
      end

      always_comb begin
         logic [NB:0] cand;
         logic        take;
         for (int l = 0; l < 3; l++) begin
            cand = (j == 0) ? {1'b0, rem_prev[l]} : {rem_prev[l], 1'b0};
            take = cand >= {1'b0, den_prev};
            rem_in[l] = take ? NB'(cand - {1'b0, den_prev}) : NB'(cand);
            q_in[l]   = {q_prev[l][QB-2:0], take};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[j] <= 1'b0;
         end else if (adv) begin
            valid_ff[j] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            den_ff[j] <= den_prev;
            rem_ff[j] <= rem_in;
            q_ff[j]   <= q_in;
            pay_ff[j] <= pay_prev;
         end
      end
   end

   assign out_valid = valid_ff[QB-1];
   assign out_q     = q_ff[QB-1];
   assign out_pay   = pay_ff[QB-1];
endmodule
`default_nettype wire

// ===== design/sphere_box_contact.sv =====
// sphere versus axis-aligned box contact test, fully pipelined
// throughput: one word per cycle; three front stages, one square root stage
// per root bit, one divider stage per quotient bit, one output register
// a stalled output freezes the whole pipe; reset clears all valid bits
`default_nettype none
module sphere_box_contact #(
   parameter int WORD_BITS = sbc_pkg::WORD_BITS_DEF,
   parameter int FRAC_BITS = sbc_pkg::FRAC_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic signed [WORD_BITS-1:0] req_sphere_x,
   input  logic signed [WORD_BITS-1:0] req_sphere_y,
   input  logic signed [WORD_BITS-1:0] req_sphere_z,
   input  logic        [WORD_BITS-2:0] req_sphere_radius,
   input  logic signed [WORD_BITS-1:0] req_box_min_x,
   input  logic signed [WORD_BITS-1:0] req_box_min_y,
   input  logic signed [WORD_BITS-1:0] req_box_min_z,
   input  logic signed [WORD_BITS-1:0] req_box_max_x,
   input  logic signed [WORD_BITS-1:0] req_box_max_y,
   input  logic signed [WORD_BITS-1:0] req_box_max_z,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_hit,
   output logic        [WORD_BITS-2:0] rsp_depth,
   output logic signed [FRAC_BITS+1:0] rsp_normal_x,
   output logic signed [FRAC_BITS+1:0] rsp_normal_y,
   output logic signed [FRAC_BITS+1:0] rsp_normal_z
);
   import sbc_pkg::*;

   localparam int W   = WORD_BITS;
   localparam int F   = FRAC_BITS;
   localparam int DW  = 2 * W - 2;
   localparam int RB  = W - 1;
   localparam int QB  = F + 2;
   localparam int SPW = 5 * W + 6;
   localparam int DPW = W + 7;
   localparam logic [W-2:0] DEPTH_MAX = '1;
   localparam logic signed [F+1:0] ONE = (F+2)'(1) << F;

   logic adv;
   logic rsp_valid_ff;

   assign adv       = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;

   // stage 1: clamp, deltas, face depths
   logic signed [W-1:0] c [3], mn [3], mx [3];
   logic        [W-1:0] mag_in [3];
   logic        [2:0]   neg_in, sneg_in;
   logic signed [W+2:0] face_in [3];

   assign c  = '{req_sphere_x, req_sphere_y, req_sphere_z};
   assign mn = '{req_box_min_x, req_box_min_y, req_box_min_z};
   assign mx = '{req_box_max_x, req_box_max_y, req_box_max_z};

   always_comb begin
      logic signed [W-1:0] cl;
      logic signed [W:0]   dl;
      logic signed [W+2:0] s, sa;
      for (int i = 0; i < 3; i++) begin
         cl = (c[i] < mn[i]) ? mn[i] : c[i];
         if (cl > mx[i]) begin
            cl = mx[i];
         end
         dl = (W+1)'(cl) - (W+1)'(c[i]);
         neg_in[i] = dl[W];
         mag_in[i] = dl[W] ? W'(-dl) : W'(dl);
         s  = ((W+3)'(c[i]) <<< 1) - (W+3)'(mn[i]) - (W+3)'(mx[i]);
         sa = s[W+2] ? -s : s;
         sneg_in[i]  = s[W+2];
         face_in[i] = (W+3)'(mx[i]) - (W+3)'(mn[i]) - sa;
      end
   end

   logic                valid1_ff;
   logic        [W-1:0] mag1_ff [3];
   logic        [2:0]   neg1_ff, sneg1_ff;
   logic signed [W+2:0] face1_ff [3];
   logic        [W-2:0] r1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
      end else if (adv) begin
         valid1_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mag1_ff  <= mag_in;
         neg1_ff  <= neg_in;
         sneg1_ff <= sneg_in;
         face1_ff <= face_in;
         r1_ff    <= req_sphere_radius;
      end
   end

   // stage 2: squares and least-deep face
   axis_type            axis_in;
   logic        [2*W-1:0] sq_in [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sq_in[i] = (2*W)'(mag1_ff[i]) * (2*W)'(mag1_ff[i]);
      end
      axis_in = AXIS_X;
      if (face1_ff[1] < face1_ff[0]) begin
         axis_in = AXIS_Y;
      end
      if (face1_ff[2] < face1_ff[axis_in]) begin
         axis_in = AXIS_Z;
      end
   end

   logic                 valid2_ff;
   logic        [2*W-1:0] sq2_ff [3];
   logic        [DW-1:0] rr2_ff;
   axis_type             axis2_ff;
   logic signed [W+2:0]  face2_ff;
   logic                 dir2_ff;
   logic        [W-1:0]  mag2_ff [3];
   logic        [2:0]    neg2_ff;
   logic        [W-2:0]  r2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid2_ff <= 1'b0;
      end else if (adv) begin
         valid2_ff <= valid1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sq2_ff   <= sq_in;
         rr2_ff   <= DW'(r1_ff) * DW'(r1_ff);
         axis2_ff <= axis_in;
         face2_ff <= face1_ff[axis_in];
         dir2_ff  <= sneg1_ff[axis_in];
         mag2_ff  <= mag1_ff;
         neg2_ff  <= neg1_ff;
         r2_ff    <= r1_ff;
      end
   end

   // stage 3: squared distance, hit test, inside depth
   logic [2*W+1:0] sum_in;
   logic           hit_in, inside_in;
   logic [W-2:0]   din_in;

   always_comb begin
      logic signed [W+2:0] t;
      logic        [W+1:0] th;
      sum_in    = (2*W+2)'(sq2_ff[0]) + (2*W+2)'(sq2_ff[1]) + (2*W+2)'(sq2_ff[2]);
      hit_in    = sum_in <= (2*W+2)'(rr2_ff);
      inside_in = sum_in == '0;
      t  = (W+3)'({r2_ff, 1'b0}) + face2_ff;
      th = (W+2)'(t >>> 1);
      if (t[W+2]) begin
         din_in = '0;
      end else if (th > (W+2)'(DEPTH_MAX)) begin
         din_in = DEPTH_MAX;
      end else begin
         din_in = th[W-2:0];
      end
   end

   logic           valid3_ff;
   logic [DW-1:0]  d3_ff;
   logic [SPW-1:0] pay3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid3_ff <= 1'b0;
      end else if (adv) begin
         valid3_ff <= valid2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d3_ff   <= hit_in ? sum_in[DW-1:0] : '0;
         pay3_ff <= {mag2_ff[0], mag2_ff[1], mag2_ff[2], neg2_ff, hit_in, inside_in,
                     din_in, 2'(axis2_ff), dir2_ff, r2_ff};
      end
   end

   // square root pipeline
   logic           sq_valid;
   logic [RB-1:0]  sq_root;
   logic [SPW-1:0] sq_pay;

   sbc_sqrt #(.RB(RB), .PW(SPW)) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (valid3_ff),
      .in_d      (d3_ff),
      .in_pay    (pay3_ff),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_pay   (sq_pay)
   );

   logic [W-1:0] s_mag [3];
   logic [2:0]   s_neg;
   logic         s_hit, s_inside, s_dir;
   logic [W-2:0] s_din, s_r, s_depth;
   logic [1:0]   s_axis;
   logic [W-2:0] s_num [3];

   assign {s_mag[0], s_mag[1], s_mag[2], s_neg, s_hit, s_inside, s_din, s_axis, s_dir, s_r}
      = sq_pay;
   assign s_depth = s_inside ? s_din : s_r - sq_root;
   assign s_num   = '{s_mag[0][W-2:0], s_mag[1][W-2:0], s_mag[2][W-2:0]};

   // normal divider pipeline
   logic           dv_valid;
   logic [QB-1:0]  dv_q [3];
   logic [DPW-1:0] dv_pay;

   sbc_div #(.NB(W-1), .QB(QB), .PW(DPW)) u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (sq_valid),
      .in_den    (sq_root),
      .in_num    (s_num),
      .in_pay    ({s_neg, s_hit, s_inside, s_axis, s_dir, s_depth}),
      .out_valid (dv_valid),
      .out_q     (dv_q),
      .out_pay   (dv_pay)
   );

   logic [2:0]   v_neg;
   logic         v_hit, v_inside, v_dir;
   logic [1:0]   v_axis;
   logic [W-2:0] v_depth;

   assign {v_neg, v_hit, v_inside, v_axis, v_dir, v_depth} = dv_pay;

   // output stage: rounding, limit, face normal, miss
   logic signed [F+1:0] nrm_in [3];
   logic [W-2:0]        depth_in;

   always_comb begin
      logic [QB:0]   qs;
      logic [QB-1:0] qr;
      for (int i = 0; i < 3; i++) begin
         qs = ((QB+1)'(dv_q[i]) + (QB+1)'(1)) >> 1;
         qr = QB'(qs);
         if (qr > QB'(ONE)) begin
            qr = QB'(ONE);
         end
         if (!v_hit) begin
            nrm_in[i] = '0;
         end else if (v_inside) begin
            if (axis_type'(v_axis) == axis_type'(i)) begin
               nrm_in[i] = v_dir ? ONE : -ONE;
            end else begin
               nrm_in[i] = '0;
            end
         end else begin
            nrm_in[i] = v_neg[i] ? -$signed(qr) : $signed(qr);
         end
      end
      depth_in = v_hit ? v_depth : '0;
   end

   logic                rsp_hit_ff;
   logic [W-2:0]        rsp_depth_ff;
   logic signed [F+1:0] rsp_nrm_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_hit_ff   <= v_hit;
         rsp_depth_ff <= depth_in;
         rsp_nrm_ff   <= nrm_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_hit      = rsp_hit_ff;
   assign rsp_depth    = rsp_depth_ff;
   assign rsp_normal_x = rsp_nrm_ff[0];
   assign rsp_normal_y = rsp_nrm_ff[1];
   assign rsp_normal_z = rsp_nrm_ff[2];
endmodule
`default_nettype wire

// ===== design/sbc_checker.sv =====
// port level checks for the sphere box contact block, bound to the top level
`default_nettype none
`include "sphere_box_contact_macros.svh"
module sbc_checker #(
   parameter int WORD_BITS = sbc_pkg::WORD_BITS_DEF,
   parameter int FRAC_BITS = sbc_pkg::FRAC_BITS_DEF
) (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_stall,
   input logic signed [WORD_BITS-1:0] req_sphere_x,
   input logic signed [WORD_BITS-1:0] req_sphere_y,
   input logic signed [WORD_BITS-1:0] req_sphere_z,
   input logic        [WORD_BITS-2:0] req_sphere_radius,
   input logic signed [WORD_BITS-1:0] req_box_min_x,
   input logic signed [WORD_BITS-1:0] req_box_min_y,
   input logic signed [WORD_BITS-1:0] req_box_min_z,
   input logic signed [WORD_BITS-1:0] req_box_max_x,
   input logic signed [WORD_BITS-1:0] req_box_max_y,
   input logic signed [WORD_BITS-1:0] req_box_max_z,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic                        rsp_hit,
   input logic        [WORD_BITS-2:0] rsp_depth,
   input logic signed [FRAC_BITS+1:0] rsp_normal_x,
   input logic signed [FRAC_BITS+1:0] rsp_normal_y,
   input logic signed [FRAC_BITS+1:0] rsp_normal_z
);
   localparam logic signed [FRAC_BITS+1:0] ONE = (FRAC_BITS+2)'(1) << FRAC_BITS;

   `SBC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_depth) && $stable(rsp_hit), "stalled word changed")
   `SBC_ASSERT_NOW(a_stall_back, clock, reset, rsp_valid && rsp_stall, req_stall,
      "input taken while output stalled")
   `SBC_ASSERT_NOW(a_miss_zero, clock, reset, rsp_valid && !rsp_hit,
      rsp_depth == '0 && rsp_normal_x == '0 && rsp_normal_y == '0 && rsp_normal_z == '0,
      "miss word not zero")
   `SBC_ASSERT_NOW(a_unit_range, clock, reset, rsp_valid,
      rsp_normal_x <= ONE && rsp_normal_x >= -ONE && rsp_normal_y <= ONE &&
      rsp_normal_y >= -ONE && rsp_normal_z <= ONE && rsp_normal_z >= -ONE,
      "normal out of range")
endmodule

bind sphere_box_contact sbc_checker #(
   .WORD_BITS(WORD_BITS),
   .FRAC_BITS(FRAC_BITS)
) u_sbc_checker (.*);
`default_nettype wire
